FILE: rtl/spl_pkg.sv
package spl_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int LG_FRAC   = 30;
    localparam int LG_STEPS  = LG_FRAC;
    localparam int LGI_BITS  = 6;
    localparam int ZI_BITS   = 9;
    localparam int Z_INT_LIM = 7;

    localparam logic signed [WORD_BITS-1:0] ONE      = WORD_BITS'(1) << FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] NEG_ONE  = -ONE;
    localparam logic signed [WORD_BITS-1:0] NEG_TWO  = -(ONE <<< 1);
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [ZI_BITS-1:0]   ZI_SAT   = ZI_BITS'(WORD_BITS - 2 - FRAC_BITS);

    localparam logic [1:0] OP_VALUE  = 2'd0;
    localparam logic [1:0] OP_DERIV1 = 2'd1;
    localparam logic [1:0] OP_DERIV2 = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] REG_SCALE_A    = 2'd0;
    localparam logic [1:0] REG_SLOPE_B    = 2'd1;
    localparam logic [1:0] REG_EXPONENT_N = 2'd2;

    typedef struct packed {
        logic                        valid;
        logic [1:0]                  op;
        logic                        dom;
        logic                        sat;
        logic signed [WORD_BITS-1:0] c;
    } meta_t;

    typedef struct packed {
        meta_t                       meta;
        logic signed [WORD_BITS-1:0] base;
        logic signed [WORD_BITS-1:0] e;
    } front_t;

    typedef struct packed {
        meta_t                       meta;
        logic signed [WORD_BITS-1:0] e;
        logic signed [LGI_BITS-1:0]  ti;
        logic [LG_FRAC:0]            m;
        logic [LG_FRAC-1:0]          frac;
    } log_t;

    typedef struct packed {
        meta_t                      meta;
        logic                       psat;
        logic signed [ZI_BITS-1:0]  zi;
        logic [LG_FRAC-1:0]         zf;
        logic [LG_FRAC:0]           acc;
    } exp_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] y;
        logic                        dom;
        logic                        sat;
    } res_t;

    typedef struct packed {
        logic                        ovf;
        logic signed [WORD_BITS-1:0] sum;
    } add_t;

    // Saturating add on words.
    function automatic add_t qadd(input logic signed [WORD_BITS-1:0] a,
                                  input logic signed [WORD_BITS-1:0] b);
        logic signed [WORD_BITS:0] s;
        add_t o;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        o.ovf = s[WORD_BITS] != s[WORD_BITS-1];
        if (!o.ovf)
        begin
            o.sum = s[WORD_BITS-1:0];
        end
        else if (s[WORD_BITS])
        begin
            o.sum = ~WORD_MAX;
        end
        else
        begin
            o.sum = WORD_MAX;
        end
        return o;
    endfunction

    // Root factor 2^(2^-(idx+1)) with LG_FRAC fraction bits, each one the floor
    // square root of the one before. Evaluated at elaboration only.
    function automatic logic [LG_FRAC:0] root_factor(input int idx);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        r = 64'd2 << LG_FRAC;
        for (int j = 0; j <= idx; j++)
        begin
            v = r << LG_FRAC;
            res = 64'd0;
            bit_w = 64'd1 << 62;
            for (int k = 0; k < 32; k++)
            begin
                if (v >= res + bit_w)
                begin
                    v = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            r = res;
        end
        return r[LG_FRAC:0];
    endfunction

endpackage

FILE: rtl/shifted_power_law_eval_unit.sv
// Shifted power law evaluator: y = a*(1+b*x)^n, or its first or second
// derivative, in signed Q16.16.
// Input channel s_*: one request per x sample; s_tuser selects the operation
// (0 value, 1 first derivative, 2 second derivative, 3 gives zero).
// Output channel m_*: one result per request, in order; m_tuser carries the
// domain error flag (base not positive, y zero) and the saturation flag.
// Configuration channel cfg_*: writes a, b or n by index; always ready. Write
// only while no request is in flight.
// Throughput is one request per cycle while s_tready is high. The pipeline
// depth is set by the 30 log2 squaring cells and the 30 exp2 root-factor
// cells, plus the multiply stages around them.
// When the receiver stalls, the output register holds its result and a
// one-entry skid register catches the next one; after that the whole pipeline
// freezes and s_tready drops until the skid entry drains.
// Reset clears the coefficients to zero and empties the pipeline.
module shifted_power_law_eval_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] x_value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] y_value
    output logic [1:0]  m_tuser,   // [0] domain_error, [1] saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int W  = spl_pkg::WORD_BITS;
    localparam int LF = spl_pkg::LG_FRAC;
    localparam int NS = spl_pkg::LG_STEPS;
    localparam int ZP = W + LF + spl_pkg::LGI_BITS;

    typedef struct packed {
        spl_pkg::meta_t meta;
        logic           neg;
        logic [ZP-1:0]  prod;
    } za_t;

    typedef struct packed {
        spl_pkg::meta_t      meta;
        logic signed [W-1:0] p;
    } sc_t;

    logic signed [W-1:0] scale_a_reg;
    logic signed [W-1:0] slope_b_reg;
    logic signed [W-1:0] exponent_n_reg;

    logic                en;
    logic                accept;
    spl_pkg::front_t     front;

    spl_pkg::log_t       norm_next;
    spl_pkg::log_t       lg [NS+1];
    logic [4:0]          lead;

    logic signed [LF+spl_pkg::LGI_BITS-1:0] lg_val;
    logic [LF+spl_pkg::LGI_BITS-1:0]        mag_lg;
    logic [W-1:0]                            mag_e;
    za_t                                     za_next;
    za_t                                     za_reg;

    logic [ZP-1:0]         z_rnd;
    logic [ZP-1:0]         z_q;
    logic [ZP-1:0]         z_lim;
    logic [LF+7:0]         z_mag;
    logic signed [LF+8:0]  z_val;
    spl_pkg::exp_t         ex0_next;
    spl_pkg::exp_t         ex [NS+1];

    logic signed [9:0]     sc_s;
    logic [9:0]            sc_sh;
    sc_t                   sc_next;
    sc_t                   sc_reg;

    logic signed [W-1:0]   q_r;
    logic                  q_ovf;
    spl_pkg::meta_t        fin_reg [2];
    spl_pkg::res_t         arr;

    logic                  out_valid_reg;
    spl_pkg::res_t         out_reg;
    logic                  skid_valid_reg;
    spl_pkg::res_t         skid_reg;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_a_reg    <= '0;
            slope_b_reg    <= '0;
            exponent_n_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                spl_pkg::REG_SCALE_A:    scale_a_reg    <= cfg_data;
                spl_pkg::REG_SLOPE_B:    slope_b_reg    <= cfg_data;
                spl_pkg::REG_EXPONENT_N: exponent_n_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    spl_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(accept), .op(s_tuser),
        .x_value(s_tdata), .scale_a(scale_a_reg), .slope_b(slope_b_reg),
        .exponent_n(exponent_n_reg), .dout(front)
    );

    // Leading one gives the integer part of log2; mantissa lands in [1,2).
    always_comb
    begin
        lead = '0;
        for (int i = 0; i <= LF; i++)
        begin
            if (front.base[i])
            begin
                lead = 5'(i);
            end
        end
        norm_next.meta = front.meta;
        norm_next.e = front.e;
        norm_next.ti = spl_pkg::LGI_BITS'(lead) - spl_pkg::LGI_BITS'(spl_pkg::FRAC_BITS);
        norm_next.m = front.base[LF:0] << (5'(LF) - lead);
        norm_next.frac = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg[0] <= '0;
        end
        else if (en)
        begin
            lg[0] <= norm_next;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_log
        spl_log_cell #(.IDX(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .din(lg[i]), .dout(lg[i+1])
        );
    end

    // z = e * log2(base), rounded, magnitude clamped to 128.
    always_comb
    begin
        lg_val = {lg[NS].ti, lg[NS].frac};
        mag_lg = lg_val[LF+spl_pkg::LGI_BITS-1] ? (LF+spl_pkg::LGI_BITS)'(-lg_val)
                                               : (LF+spl_pkg::LGI_BITS)'(lg_val);
        mag_e = lg[NS].e[W-1] ? W'(-lg[NS].e) : W'(lg[NS].e);
        za_next.meta = lg[NS].meta;
        za_next.neg = lg[NS].e[W-1] != lg_val[LF+spl_pkg::LGI_BITS-1];
        za_next.prod = ZP'(mag_e) * ZP'(mag_lg);
    end

    always_comb
    begin
        z_rnd = za_reg.prod + (ZP'(1) << (spl_pkg::FRAC_BITS - 1));
        z_q = z_rnd >> spl_pkg::FRAC_BITS;
        z_lim = ZP'(1) << (LF + spl_pkg::Z_INT_LIM);
        z_mag = (z_q > z_lim) ? z_lim[LF+7:0] : z_q[LF+7:0];
        z_val = za_reg.neg ? -$signed({1'b0, z_mag}) : $signed({1'b0, z_mag});
        ex0_next.meta = za_reg.meta;
        ex0_next.zi = z_val[LF+8:LF];
        ex0_next.zf = z_val[LF-1:0];
        ex0_next.acc = (LF+1)'(1) << LF;
        ex0_next.psat = $signed(z_val[LF+8:LF]) > spl_pkg::ZI_SAT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            za_reg <= '0;
            ex[0]  <= '0;
        end
        else if (en)
        begin
            za_reg <= za_next;
            ex[0]  <= ex0_next;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_exp
        spl_exp_cell #(.IDX(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .din(ex[i]), .dout(ex[i+1])
        );
    end

    // Scale the power from LG_FRAC to FRAC_BITS fraction bits, rounding; a power too large saturates.
    always_comb
    begin
        sc_s = {ex[NS].zi[spl_pkg::ZI_BITS-1], ex[NS].zi}
             + 10'(spl_pkg::FRAC_BITS - LF);
        sc_sh = 10'(-sc_s);
        sc_next.meta = ex[NS].meta;
        sc_next.meta.sat = ex[NS].meta.sat | ex[NS].psat;
        if (ex[NS].psat)
        begin
            sc_next.p = spl_pkg::WORD_MAX;
        end
        else if (sc_s >= 0)
        begin
            sc_next.p = W'(ex[NS].acc);
        end
        else if (sc_sh > 10'd32)
        begin
            sc_next.p = '0;
        end
        else
        begin
            sc_next.p = W'((33'(ex[NS].acc) + (33'd1 << (sc_sh - 10'd1))) >> sc_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg     <= '0;
            fin_reg[0] <= '0;
            fin_reg[1] <= '0;
        end
        else if (en)
        begin
            sc_reg     <= sc_next;
            fin_reg[0] <= sc_reg.meta;
            fin_reg[1] <= fin_reg[0];
        end
    end

    spl_qmul u_qfin (
        .clk(clk), .rst_n(rst_n), .en(en), .a(sc_reg.meta.c), .b(sc_reg.p),
        .r(q_r), .ovf(q_ovf)
    );

    always_comb
    begin
        arr.y = '0;
        arr.dom = 1'b0;
        arr.sat = 1'b0;
        if (fin_reg[1].op != spl_pkg::OP_NONE)
        begin
            if (fin_reg[1].dom)
            begin
                arr.dom = 1'b1;
            end
            else
            begin
                arr.y = q_r;
                arr.sat = fin_reg[1].sat | q_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fin_reg[1].valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_reg       <= arr;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= arr;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.y;
    assign m_tuser  = {out_reg.sat, out_reg.dom};

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid entry not drained after output request taken");

    a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("domain error result is not a clean zero");
`endif

endmodule

FILE: rtl/spl_qmul.sv
module spl_qmul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  a,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  b,
    output logic signed [spl_pkg::WORD_BITS-1:0]  r,
    output logic                                  ovf
);

    localparam int W = spl_pkg::WORD_BITS;

    logic [W-1:0]          mag_a;
    logic [W-1:0]          mag_b;
    logic [2*W-1:0]        prod_next;
    logic [2*W-1:0]        prod_reg;
    logic                  neg_reg;
    logic [2*W-1:0]        rnd;
    logic [2*W-1:0]        q;
    logic [2*W-1:0]        lim;
    logic [2*W-1:0]        q_sat;
    logic signed [W-1:0]   r_next;
    logic                  ovf_next;
    logic signed [W-1:0]   r_reg;
    logic                  ovf_reg;

    always_comb
    begin
        mag_a = a[W-1] ? W'(-a) : W'(a);
        mag_b = b[W-1] ? W'(-b) : W'(b);
        prod_next = (2*W)'(mag_a) * (2*W)'(mag_b);
    end

    // Round to nearest with ties away from zero on the magnitude, then clip.
    always_comb
    begin
        rnd = prod_reg + ((2*W)'(1) << (spl_pkg::FRAC_BITS - 1));
        q = rnd >> spl_pkg::FRAC_BITS;
        lim = (2*W)'(spl_pkg::WORD_MAX) + (2*W)'(neg_reg);
        ovf_next = q > lim;
        q_sat = ovf_next ? lim : q;
        r_next = neg_reg ? W'(-q_sat) : W'(q_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            neg_reg  <= 1'b0;
            r_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= a[W-1] != b[W-1];
            r_reg    <= r_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign r   = r_reg;
    assign ovf = ovf_reg;

endmodule

FILE: rtl/spl_front.sv
module spl_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [1:0]                            op,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  x_value,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  scale_a,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  slope_b,
    input  logic signed [spl_pkg::WORD_BITS-1:0]  exponent_n,
    output spl_pkg::front_t                       dout
);

    localparam int W     = spl_pkg::WORD_BITS;
    localparam int DEPTH = 8;

    spl_pkg::front_t side_reg  [DEPTH];
    spl_pkg::front_t side_next [DEPTH];

    logic signed [W-1:0] q_r   [5];
    logic                q_ovf [5];
    logic signed [W-1:0] f1;
    logic signed [W-1:0] f2;
    logic signed [W-1:0] f3;
    logic signed [W-1:0] f4;
    spl_pkg::add_t       nm1;
    spl_pkg::add_t       nm2;
    spl_pkg::add_t       base_add;

    // Coefficient chain: a times up to four factors, a factor of one where the
    // operation needs fewer. The product b*x for the base 1+b*x runs beside the first product.
    always_comb
    begin
        nm1 = spl_pkg::qadd(exponent_n, spl_pkg::NEG_ONE);
        nm2 = spl_pkg::qadd(exponent_n, spl_pkg::NEG_TWO);

        case (op) inside
            spl_pkg::OP_DERIV1, spl_pkg::OP_DERIV2: f1 = slope_b;
            default:                                f1 = spl_pkg::ONE;
        endcase
        case (side_reg[1].meta.op)
            spl_pkg::OP_DERIV1: f2 = exponent_n;
            spl_pkg::OP_DERIV2: f2 = slope_b;
            default:            f2 = spl_pkg::ONE;
        endcase
        f3 = (side_reg[3].meta.op == spl_pkg::OP_DERIV2) ? exponent_n : spl_pkg::ONE;
        f4 = (side_reg[5].meta.op == spl_pkg::OP_DERIV2) ? nm1.sum : spl_pkg::ONE;

        side_next[0] = '0;
        side_next[0].meta.valid = in_valid;
        side_next[0].meta.op = op;
        case (op)
            spl_pkg::OP_DERIV1:
            begin
                side_next[0].e = nm1.sum;
                side_next[0].meta.sat = nm1.ovf;
            end
            spl_pkg::OP_DERIV2:
            begin
                side_next[0].e = nm2.sum;
                side_next[0].meta.sat = nm1.ovf | nm2.ovf;
            end
            default:
            begin
                side_next[0].e = exponent_n;
            end
        endcase

        base_add = spl_pkg::qadd(spl_pkg::ONE, q_r[0]);
        for (int k = 1; k < DEPTH; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[2].base = base_add.sum;
        side_next[2].meta.dom = base_add.sum <= 0;
        side_next[2].meta.sat = side_reg[1].meta.sat | q_ovf[0] | q_ovf[1] | base_add.ovf;
        side_next[4].meta.sat = side_reg[3].meta.sat | q_ovf[2];
        side_next[6].meta.sat = side_reg[5].meta.sat | q_ovf[3];

        dout = side_reg[DEPTH-1];
        dout.meta.c = q_r[4];
        dout.meta.sat = side_reg[DEPTH-1].meta.sat | q_ovf[4];
    end

    spl_qmul u_q0 (.clk(clk), .rst_n(rst_n), .en(en), .a(slope_b), .b(x_value),
                   .r(q_r[0]), .ovf(q_ovf[0]));
    spl_qmul u_q1 (.clk(clk), .rst_n(rst_n), .en(en), .a(scale_a), .b(f1),
                   .r(q_r[1]), .ovf(q_ovf[1]));
    spl_qmul u_q2 (.clk(clk), .rst_n(rst_n), .en(en), .a(q_r[1]), .b(f2),
                   .r(q_r[2]), .ovf(q_ovf[2]));
    spl_qmul u_q3 (.clk(clk), .rst_n(rst_n), .en(en), .a(q_r[2]), .b(f3),
                   .r(q_r[3]), .ovf(q_ovf[3]));
    spl_qmul u_q4 (.clk(clk), .rst_n(rst_n), .en(en), .a(q_r[3]), .b(f4),
                   .r(q_r[4]), .ovf(q_ovf[4]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

endmodule

FILE: rtl/spl_log_cell.sv
module spl_log_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  spl_pkg::log_t din,
    output spl_pkg::log_t dout
);

    localparam int LF  = spl_pkg::LG_FRAC;
    localparam int BIT = LF - 1 - IDX;

    logic [2*LF+1:0] sq;
    logic [LF+1:0]   sq_sh;
    spl_pkg::log_t   cell_next;
    spl_pkg::log_t   cell_reg;

    // One fraction bit of log2 per cell: square the mantissa and renormalize.
    always_comb
    begin
        sq = (2*LF+2)'(din.m) * (2*LF+2)'(din.m);
        sq_sh = sq[2*LF+1:LF];
        cell_next = din;
        if (sq_sh[LF+1])
        begin
            cell_next.m = sq_sh[LF+1:1];
            cell_next.frac[BIT] = 1'b1;
        end
        else
        begin
            cell_next.m = sq_sh[LF:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: rtl/spl_exp_cell.sv
module spl_exp_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  spl_pkg::exp_t din,
    output spl_pkg::exp_t dout
);

    localparam int LF = spl_pkg::LG_FRAC;
    localparam int BIT = LF - 1 - IDX;
    localparam logic [LF:0] ROOT = spl_pkg::root_factor(IDX);

    logic [2*LF+1:0] prod;
    spl_pkg::exp_t   cell_next;
    spl_pkg::exp_t   cell_reg;

    always_comb
    begin
        prod = (2*LF+2)'(din.acc) * (2*LF+2)'(ROOT);
        cell_next = din;
        if (din.zf[BIT])
        begin
            cell_next.acc = prod[2*LF:LF];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
